// ===== src/wmef_pkg.sv =====
// package: word types, walk phases and fixed-parameter lengths for the element finder
`timescale 1ns / 1ps

package wmef_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 255;
	localparam int unsigned HEADER_BYTES        = 24;
	localparam int unsigned FCS_BYTES           = 4;
	localparam int unsigned TLV_HDR_BYTES       = 2;
	localparam logic [1:0]  TYPE_MGMT           = 2'd0;
	localparam logic [8:0]  POS_LIMIT           = 9'd511;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_start;
		logic [7:0] frame_length;
		logic [7:0] wanted_tag;
	} in_word_t;

	typedef struct packed {
		logic       found;
		logic [7:0] content_offset;
		logic [7:0] content_length;
	} out_word_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TAG  = 2'd1,
		PH_LEN  = 2'd2
	} phase_t;

	// fixed-parameter bytes of a management frame, by subtype
	function automatic logic [3:0] fixed_len(input logic [3:0] subtype);
		logic [3:0] len;
		unique case (subtype)
			4'd0:    len = 4'd4;
			4'd1:    len = 4'd6;
			4'd2:    len = 4'd10;
			4'd3:    len = 4'd6;
			4'd5:    len = 4'd12;
			4'd8:    len = 4'd12;
			4'd10:   len = 4'd2;
			4'd11:   len = 4'd6;
			4'd12:   len = 4'd2;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== src/wmef_in_if.sv =====
// interface: frame byte channel
`timescale 1ns / 1ps

interface wmef_in_if;
	logic              valid;
	logic              ready;
	wmef_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/wmef_out_if.sv =====
// interface: search result channel
`timescale 1ns / 1ps

interface wmef_out_if;
	logic               valid;
	logic               ready;
	wmef_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/wmef_walker.sv =====
// module: per-byte element walk state and result decision
`timescale 1ns / 1ps

module wmef_walker #(
	parameter int unsigned MAX_FRAME_BYTES = wmef_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wmef_pkg::in_word_t  word,
	output logic                res_valid,
	output wmef_pkg::out_word_t res
);
	import wmef_pkg::*;

	localparam int unsigned LenCap = (MAX_FRAME_BYTES > 255) ? 255 : MAX_FRAME_BYTES;

	logic [8:0] pos_q, pos_d;
	logic [8:0] nes_q, nes_d;
	logic [7:0] body_end_q, body_end_d;
	logic [7:0] tag_q, tag_d;
	phase_t     phase_q, phase_d;
	logic       matched_q, matched_d;

	logic [7:0] len_clamped;
	logic [3:0] fixed;
	logic [8:0] first_start;
	logic [7:0] start_body_end;
	logic [8:0] next_start;
	logic [8:0] content_pos;

	always_comb begin
		len_clamped    = (word.frame_length > 8'(LenCap)) ? 8'(LenCap) : word.frame_length;
		start_body_end = (len_clamped >= 8'(FCS_BYTES)) ? (len_clamped - 8'(FCS_BYTES)) : 8'd0;
		fixed          = (word.frame_byte[3:2] == TYPE_MGMT) ?
			fixed_len(word.frame_byte[7:4]) : 4'd0;
		first_start    = 9'(HEADER_BYTES) + {5'd0, fixed};
		content_pos    = nes_q + 9'(TLV_HDR_BYTES);
		next_start     = content_pos + {1'b0, word.frame_byte};
	end

	// next state and result
	always_comb begin
		pos_d      = pos_q;
		nes_d      = nes_q;
		body_end_d = body_end_q;
		tag_d      = tag_q;
		phase_d    = phase_q;
		matched_d  = matched_q;
		res_valid  = 1'b0;
		res        = '0;
		if (word.frame_start) begin
			body_end_d = start_body_end;
			tag_d      = word.wanted_tag;
			matched_d  = 1'b0;
			nes_d      = first_start;
			if (first_start >= {1'b0, start_body_end}) begin
				res_valid = 1'b1;
				phase_d   = PH_IDLE;
			end else begin
				phase_d = PH_TAG;
			end
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					if (pos_q == nes_q) begin
						matched_d = (word.frame_byte == tag_q);
						phase_d   = PH_LEN;
					end
				end
				PH_LEN: begin
					if (matched_q) begin
						res_valid          = 1'b1;
						res.found          = 1'b1;
						res.content_offset = content_pos[7:0];
						res.content_length = word.frame_byte;
						phase_d            = PH_IDLE;
					end else begin
						nes_d = next_start;
						if (next_start >= {1'b0, body_end_q}) begin
							res_valid = 1'b1;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_TAG;
						end
					end
					matched_d = 1'b0;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (word.frame_start) begin
			pos_d = 9'd1;
		end else if (pos_q != POS_LIMIT) begin
			pos_d = pos_q + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			nes_q      <= '0;
			body_end_q <= '0;
			tag_q      <= '0;
			phase_q    <= PH_IDLE;
			matched_q  <= 1'b0;
		end else if (step) begin
			pos_q      <= pos_d;
			nes_q      <= nes_d;
			body_end_q <= body_end_d;
			tag_q      <= tag_d;
			phase_q    <= phase_d;
			matched_q  <= matched_d;
		end
	end

	a_found_from_len: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.found |-> phase_q == PH_LEN && !word.frame_start)
		else $error("found result outside length byte");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.content_offset == 8'd0 && res.content_length == 8'd0)
		else $error("not-found result carries nonzero fields");

	a_decided_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> phase_q == PH_IDLE)
		else $error("walk continues after result");

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		step && !word.frame_start && phase_q == PH_IDLE |=> phase_q == PH_IDLE)
		else $error("walk left idle without frame start");

endmodule

// ===== src/wifi_mgmt_element_finder_top.sv =====
// top level: information element finder with input and result registers
//
// channel   dir  word fields
// frames    in   frame_byte, frame_start, frame_length, wanted_tag
// results   out  found, content_offset, content_length
//
// one frame byte per cycle while results are not stalled; the deciding byte passes the
// input register, then the walk logic writes the result register
// a stalled result holds the result register; the input register still fills
// arst_n clears valid flags and the walk state to idle
`timescale 1ns / 1ps

module wifi_mgmt_element_finder_top #(
	parameter int unsigned MAX_FRAME_BYTES = wmef_pkg::MAX_FRAME_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	wmef_in_if.sink    frames,
	wmef_out_if.source results
);
	import wmef_pkg::*;

	logic      valid_s1;
	in_word_t  data_s1;
	logic      out_valid_q;
	out_word_t out_data_q;
	logic      out_free;
	logic      advance;
	logic      res_valid;
	out_word_t res;

	assign out_free     = !out_valid_q || results.ready;
	assign advance      = valid_s1 && out_free;
	assign frames.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.ready && frames.valid) begin
			data_s1 <= frames.data;
		end
	end

	wmef_walker #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.word     (data_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

endmodule

// ===== tb/sv/wifi_mgmt_element_finder_top_tb.sv =====
// testbench: frame byte stream into the element finder, results checked against a walk predictor
`timescale 1ns / 1ps

module wifi_mgmt_element_finder_top_tb;
	import wmef_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 4000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PHASE_BYTES = 335;
	// fixed-parameter bytes by management subtype, subtype 15 in the top nibble
	localparam logic [63:0] FIXED_NIBBLES = {4'd0, 4'd0, 4'd0, 4'd2, 4'd6, 4'd2, 4'd0, 4'd12,
		4'd0, 4'd0, 4'd12, 4'd0, 4'd6, 4'd10, 4'd6, 4'd4};

	typedef struct packed {
		logic [8:0] pos;
		logic [8:0] next_start;
		logic [7:0] body_end;
		logic [7:0] tag;
		phase_t     phase;
		logic       matched;
	} walk_t;

	logic clk = 1'b0;
	logic arst_n;

	wmef_in_if frames_if ();
	wmef_out_if results_if ();

	wifi_mgmt_element_finder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_if),
		.results(results_if)
	);

	in_word_t  byte_q[$];
	out_word_t expected_q[$];
	walk_t     plan_st;
	walk_t     dut_model;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        live_bytes;
	int        frames_sent;
	int        results_seen;
	int        found_seen;
	int        errors;
	int        quiet_cycles;

	function automatic int fixed_param_bytes(input logic [7:0] fc);
		return (fc[3:2] == TYPE_MGMT) ? int'(FIXED_NIBBLES[fc[7:4] * 4 +: 4]) : 0;
	endfunction

	// advance the element walk by one word; returns 1 when the frame is decided
	function automatic bit walk_byte(inout walk_t st, input in_word_t w, output out_word_t r);
		int  len;
		int  nxt;
		bit  got;
		got = 0;
		r = '0;
		if (w.frame_start) begin
			len = w.frame_length;
			if (len > int'(MAX_FRAME_BYTES_DEF))
				len = MAX_FRAME_BYTES_DEF;
			st.body_end = (len >= int'(FCS_BYTES)) ? 8'(len - FCS_BYTES) : 8'd0;
			st.tag = w.wanted_tag;
			st.matched = 1'b0;
			st.pos = '0;
			st.next_start = 9'(HEADER_BYTES + fixed_param_bytes(w.frame_byte));
			if (st.next_start >= 9'(st.body_end)) begin
				got = 1;
				st.phase = PH_IDLE;
			end else begin
				st.phase = PH_TAG;
			end
		end else if (st.phase == PH_TAG) begin
			if (st.pos == st.next_start) begin
				st.matched = (w.frame_byte == st.tag);
				st.phase = PH_LEN;
			end
		end else if (st.phase == PH_LEN) begin
			if (st.matched) begin
				r.found = 1'b1;
				r.content_offset = 8'(st.next_start + TLV_HDR_BYTES);
				r.content_length = w.frame_byte;
				got = 1;
				st.phase = PH_IDLE;
			end else begin
				nxt = int'(st.next_start) + TLV_HDR_BYTES + int'(w.frame_byte);
				st.next_start = 9'(nxt);
				if (st.next_start >= 9'(st.body_end)) begin
					got = 1;
					st.phase = PH_IDLE;
				end else begin
					st.phase = PH_TAG;
				end
			end
			st.matched = 1'b0;
		end else begin
			st.phase = PH_IDLE;
		end
		if (st.pos < POS_LIMIT)
			st.pos = st.pos + 9'd1;
		return got;
	endfunction

	function automatic in_word_t mk_word(input logic [7:0] b, input logic s,
			input logic [7:0] flen, input logic [7:0] tag);
		in_word_t w;
		w.frame_byte = b;
		w.frame_start = s;
		w.frame_length = flen;
		w.wanted_tag = tag;
		return w;
	endfunction

	task automatic queue_byte(input in_word_t w, output bit done);
		out_word_t unused;
		if (w.frame_start || plan_st.phase != PH_IDLE)
			live_bytes++;
		done = walk_byte(plan_st, w, unused);
		byte_q.push_back(w);
	endtask

	task automatic queue_random_frame();
		logic [7:0] frame_img [512];
		logic [7:0] fc;
		logic [7:0] flen;
		logic [7:0] want;
		in_word_t   w;
		int         pos;
		int         pick;
		int         abandon_at;
		int         trail;
		int         i;
		bit         noise;
		bit         done;
		noise = ($urandom_range(99) < 10);
		fc = 8'($urandom_range(255));
		if ($urandom_range(99) < 70)
			fc[3:2] = TYPE_MGMT;
		pick = $urandom_range(99);
		if (pick < 10)
			flen = 8'($urandom_range(30));
		else if (pick < 90)
			flen = 8'($urandom_range(110, 30));
		else
			flen = 8'($urandom_range(255, 110));
		want = ($urandom_range(99) < 60) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
		for (i = 0; i < 512; i++)
			frame_img[i] = 8'($urandom_range(255));
		frame_img[0] = fc;
		if (!noise) begin
			pos = HEADER_BYTES + fixed_param_bytes(fc);
			while (pos < 480) begin
				frame_img[pos] = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 85)
					frame_img[pos + 1] = 8'($urandom_range(15));
				else if (pick < 95)
					frame_img[pos + 1] = 8'($urandom_range(60, 16));
				else
					frame_img[pos + 1] = 8'($urandom_range(255, 61));
				pos = pos + TLV_HDR_BYTES + frame_img[pos + 1];
			end
		end
		abandon_at = ($urandom_range(99) < 8) ? $urandom_range(60, 1) : 512;
		i = 0;
		done = 0;
		while (!done && i < abandon_at && i < 512) begin
			w = mk_word(frame_img[i], i == 0, (i == 0) ? flen : 8'($urandom_range(255)),
				(i == 0) ? want : 8'($urandom_range(255)));
			queue_byte(w, done);
			i++;
		end
		trail = ($urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
		for (i = 0; i < trail; i++)
			queue_byte(mk_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
				8'($urandom_range(255))), done);
		frames_sent++;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always #4 clk = ~clk;

	// word source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_if.valid <= 1'b0;
			frames_if.data <= '0;
		end else if (!frames_if.valid || frames_if.ready) begin
			if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				frames_if.data <= byte_q.pop_front();
				frames_if.valid <= 1'b1;
			end else begin
				frames_if.valid <= 1'b0;
			end
		end
	end

	// result sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin : watch
		out_word_t pred;
		out_word_t exp_r;
		out_word_t got_r;
		if (arst_n) begin
			if (frames_if.valid && frames_if.ready) begin
				if (walk_byte(dut_model, frames_if.data, pred))
					expected_q.push_back(pred);
			end
			if (results_if.valid && results_if.ready) begin
				got_r = results_if.data;
				results_seen++;
				if (got_r.found)
					found_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%t unexpected result: found %0d offset %0d length %0d", $time,
						got_r.found, got_r.content_offset, got_r.content_length);
				end else begin
					exp_r = expected_q.pop_front();
					if (got_r.found !== exp_r.found) begin
						errors++;
						$display("%t found: expected %0d, got %0d", $time, exp_r.found,
							got_r.found);
					end
					if (got_r.content_offset !== exp_r.content_offset) begin
						errors++;
						$display("%t content_offset: expected %0d, got %0d", $time,
							exp_r.content_offset, got_r.content_offset);
					end
					if (got_r.content_length !== exp_r.content_length) begin
						errors++;
						$display("%t content_length: expected %0d, got %0d", $time,
							exp_r.content_length, got_r.content_length);
					end
				end
			end
			if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int  idle_mix [4];
		int  stall_mix [4];
		int  ph;
		int  goal;
		int  i;
		bit  done;
		idle_mix = '{0, 53, 0, 8};
		stall_mix = '{0, 0, 53, 8};
		plan_st = '0;
		dut_model = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		live_bytes = 0;
		frames_sent = 0;
		results_seen = 0;
		found_seen = 0;
		errors = 0;
		quiet_cycles = 0;
		@(negedge clk);

		// stray words with no frame, short frames, no room for elements
		queue_byte(mk_word(8'hFF, 1'b0, 8'hFF, 8'hFF), done);
		queue_byte(mk_word(8'h00, 1'b0, 8'h00, 8'h00), done);
		queue_byte(mk_word(8'h08, 1'b1, 8'h00, 8'hFF), done);
		queue_byte(mk_word(8'h00, 1'b1, 8'h03, 8'h00), done);
		queue_byte(mk_word(8'h50, 1'b1, 8'd40, 8'h05), done);
		// wanted element first, its length byte in the fcs
		queue_byte(mk_word(8'hFF, 1'b1, 8'd29, 8'h00), done);
		for (i = 1; i < 24; i++)
			queue_byte(mk_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
				8'($urandom_range(255))), done);
		queue_byte(mk_word(8'h00, 1'b0, 8'h00, 8'hFF), done);
		queue_byte(mk_word(8'hFF, 1'b0, 8'hFF, 8'h00), done);
		frames_sent += 4;

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_mix[ph];
			recv_stall_pct = stall_mix[ph];
			goal = live_bytes + PHASE_BYTES;
			while (live_bytes < goal)
				queue_random_frame();
			while (byte_q.size() > 0)
				@(negedge clk);
		end

		while (byte_q.size() > 0 || frames_if.valid || expected_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d frames, %0d walked bytes, %0d results checked (%0d found)",
			frames_sent, live_bytes, results_seen, found_seen);
		$display("idling mixes: none, source idle, sink stall, both");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results never seen", errors, expected_q.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
